/* design/ulat_pkg.sv */
`timescale 1ns / 1ps

package ulat_pkg;

    localparam int FILL_W  = 8;
    localparam int ARGS_W  = 7;
    localparam int STORE_W = 9;
    localparam int CFG_W   = 2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ARG_LO = 8'h22;
    localparam logic [7:0] CH_ARG_HI = 8'h7D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_ERROR   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_READY    = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_BUSY     = 3'd4,
        ST_CLEARED  = 3'd5,
        ST_READ     = 3'd6,
        ST_RELEASED = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        MODE_CR   = 2'd0,
        MODE_LF   = 2'd1,
        MODE_CRLF = 2'd2,
        MODE_ALT  = 2'd3
    } t_line_mode;

    typedef enum logic {
        CFG_LINE_END_MODE = 1'b0,
        CFG_AT_MODE       = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] line_length;
        logic [6:0] arg_count;
        logic [7:0] read_char;
        logic       is_arg_start;
        logic       is_separator;
    } t_out_item;

endpackage

/* design/ulat_ram.sv */
`timescale 1ns / 1ps

module ulat_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* design/uart_line_assembler_tokenizer_core.sv */
// UART command line buffer. Each transfer on the input channel carries one received byte,
// a receive error or timeout event, a read of the pending line or a release, and produces
// exactly one result transfer. One item is accepted every clock cycle while the output
// side does not stall. The line store is read at the requested index and at the one after
// it on the same edge that loads the input register, and the result register follows.
// While a result waits, one more item is held in the input register before the input is
// refused. The store holds BUFFER_LENGTH entries and needs no clearing after reset.
// Configuration registers must only be written while no item is in flight.
`timescale 1ns / 1ps

module uart_line_assembler_tokenizer_core #(
    parameter int BUFFER_LENGTH = 256,
    parameter int MAX_ARGS      = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  ulat_pkg::t_in_item      i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output ulat_pkg::t_out_item     o_out,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [ulat_pkg::CFG_W-1:0] i_cfg_data
);

    import ulat_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_LENGTH);
    localparam logic [8:0] LIMIT_CRLF = 9'(BUFFER_LENGTH - 2);
    localparam logic [8:0] LIMIT_PLAIN = 9'(BUFFER_LENGTH - 1);
    localparam logic [7:0] ARGS_LIMIT = 8'(MAX_ARGS);

    logic              r_s1_valid;
    t_in_item          r_s1;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [FILL_W-1:0] r_fill;
    logic              r_pending;
    logic [ARGS_W-1:0] r_args;
    logic [7:0]        r_prev;
    logic              r_last;
    t_line_mode        r_mode;
    logic              r_at;

    logic [FILL_W-1:0] n_fill;
    logic              n_pending;
    logic [ARGS_W-1:0] n_args;
    logic [7:0]        n_prev;
    logic              n_last;
    t_out_item         n_out;

    logic               s1_fire;
    logic               in_accept;
    logic [8:0]         rd_next;
    logic [STORE_W-1:0] ram_a;
    logic [STORE_W-1:0] ram_b;
    logic               mem_we;
    logic [STORE_W-1:0] mem_wdata;

    logic              crlf;
    logic              end_line;
    logic              mark;
    logic [7:0]        term;
    logic [FILL_W-1:0] fill_end;
    logic [ARGS_W-1:0] args_end;
    logic [7:0]        count_cur;
    logic [7:0]        count_end;
    logic [8:0]        s1_next;
    logic              rd_start;
    logic              rd_sep;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_accept  = i_in_valid && o_in_ready;
    assign rd_next    = {1'b0, i_in.read_index} + 9'd1;

    ulat_ram #(
        .WIDTH(STORE_W),
        .DEPTH(BUFFER_LENGTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (r_fill[ADDR_W-1:0]),
        .i_wdata  (mem_wdata),
        .i_re     (in_accept),
        .i_raddr_a(i_in.read_index[ADDR_W-1:0]),
        .i_raddr_b(rd_next[ADDR_W-1:0]),
        .o_rdata_a(ram_a),
        .o_rdata_b(ram_b)
    );

    always_comb begin
        crlf      = (r_mode == MODE_CRLF);
        term      = (r_mode == MODE_CR) ? CH_CR : CH_LF;
        count_cur = r_at ? 8'd1 : 8'd1 + {1'b0, r_args};
        if (crlf) begin
            end_line = (r_s1.rx_byte == CH_LF && r_prev == CH_CR)
                       || ({1'b0, r_fill} >= LIMIT_CRLF);
        end else begin
            end_line = (r_s1.rx_byte == term) || ({1'b0, r_fill} >= LIMIT_PLAIN);
        end
        mark = (r_fill != '0) && (r_prev == CH_SPACE)
               && (r_s1.rx_byte inside {[CH_ARG_LO:CH_ARG_HI]});
        fill_end = crlf ? r_fill - 8'd1 : r_fill;
        args_end = (crlf && r_last && r_args != '0) ? r_args - 7'd1 : r_args;
        count_end = r_at ? 8'd1 : 8'd1 + {1'b0, args_end};
        s1_next = {1'b0, r_s1.read_index} + 9'd1;
        rd_start = (r_s1.read_index == 8'd0)
                   || (!r_at && r_s1.read_index < r_fill && ram_a[8]);
        rd_sep = !r_at && (s1_next < {1'b0, r_fill})
                 && (ram_a[7:0] == CH_SPACE) && ram_b[8];

        n_fill    = r_fill;
        n_pending = r_pending;
        n_args    = r_args;
        n_prev    = r_prev;
        n_last    = r_last;
        n_out     = '0;
        mem_we    = 1'b0;
        mem_wdata = {mark, r_s1.rx_byte};

        case (t_cmd'(r_s1.command))
            CMD_BYTE: begin
                if (r_pending) begin
                    n_out.status      = ST_BUSY;
                    n_out.line_length = r_fill;
                    n_out.arg_count   = count_cur[6:0];
                end else if (crlf && r_fill == '0 && r_s1.rx_byte == CH_LF) begin
                    n_out.status = ST_EMPTY;
                end else if (!end_line) begin
                    mem_we = s1_fire;
                    n_fill = r_fill + 8'd1;
                    if (mark && r_args != '1) begin
                        n_args = r_args + 7'd1;
                    end
                    n_last            = mark;
                    n_prev            = r_s1.rx_byte;
                    n_out.status      = ST_STORED;
                    n_out.line_length = r_fill + 8'd1;
                end else begin
                    n_prev = '0;
                    n_last = 1'b0;
                    if (fill_end == '0) begin
                        n_fill       = '0;
                        n_args       = '0;
                        n_out.status = ST_EMPTY;
                    end else if (count_end > ARGS_LIMIT) begin
                        n_fill            = '0;
                        n_args            = '0;
                        n_out.status      = ST_TOO_MANY;
                        n_out.line_length = fill_end;
                    end else begin
                        n_fill            = fill_end;
                        n_args            = args_end;
                        n_pending         = 1'b1;
                        n_out.status      = ST_READY;
                        n_out.line_length = fill_end;
                        n_out.arg_count   = count_end[6:0];
                    end
                end
            end
            CMD_ERROR: begin
                if (r_pending) begin
                    n_out.status      = ST_BUSY;
                    n_out.line_length = r_fill;
                    n_out.arg_count   = count_cur[6:0];
                end else begin
                    n_fill       = '0;
                    n_args       = '0;
                    n_prev       = '0;
                    n_last       = 1'b0;
                    n_out.status = ST_CLEARED;
                end
            end
            CMD_READ: begin
                n_out.status = ST_READ;
                if (r_pending) begin
                    n_out.line_length  = r_fill;
                    n_out.arg_count    = count_cur[6:0];
                    n_out.read_char    = (r_s1.read_index < r_fill && !rd_sep)
                                         ? ram_a[7:0] : 8'd0;
                    n_out.is_arg_start = rd_start;
                    n_out.is_separator = rd_sep;
                end
            end
            default: begin
                if (r_pending) begin
                    n_fill    = '0;
                    n_pending = 1'b0;
                    n_args    = '0;
                    n_prev    = '0;
                    n_last    = 1'b0;
                end
                n_out.status = ST_RELEASED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_pending   <= 1'b0;
            r_args      <= '0;
            r_prev      <= '0;
            r_last      <= 1'b0;
            r_mode      <= MODE_CR;
            r_at        <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_fill      <= n_fill;
                r_pending   <= n_pending;
                r_args      <= n_args;
                r_prev      <= n_prev;
                r_last      <= n_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_LINE_END_MODE: r_mode <= t_line_mode'(i_cfg_data);
                    default:           r_at   <= i_cfg_data[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/ulat_checker.sv */
`timescale 1ns / 1ps

module ulat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ulat_pkg::t_out_item o_out
);

    import ulat_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed or vanished while stalled");

    a_ready_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused while the output side was free");

    a_plain_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_EMPTY || o_out.status == ST_CLEARED
            || o_out.status == ST_RELEASED)
        |-> o_out.line_length == 8'd0 && o_out.arg_count == 7'd0
            && o_out.read_char == 8'd0 && !o_out.is_arg_start && !o_out.is_separator)
        else $error("non-zero field on a status that carries none");

    a_separator_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_separator
        |-> o_out.status == ST_READ && o_out.read_char == 8'd0
            && o_out.line_length != 8'd0)
        else $error("separator reported outside a read or with a character");

endmodule

bind uart_line_assembler_tokenizer_core ulat_checker u_ulat_checker (.*);

/* bench/ulat_line_checker.sv */
`timescale 1ns / 1ps

module ulat_line_checker #(
    parameter int BUFFER_LENGTH = 256,
    parameter int MAX_ARGS      = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  ulat_pkg::t_in_item   i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  ulat_pkg::t_out_item  i_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [ulat_pkg::CFG_W-1:0] i_cfg_data,
    output int                   o_outstanding,
    output int                   o_failures
);

    import ulat_pkg::*;

    logic [8:0]  line_mem [256];
    logic [7:0]  fill;
    logic        held;
    logic [6:0]  marks_seen;
    logic [7:0]  prev_byte;
    logic        prev_marked;
    t_line_mode  end_mode;
    logic        whole_line_arg;

    t_out_item   due_replies [$];
    int          fail_tally = 0;

    assign o_failures = fail_tally;

    function automatic void drop_line();
        fill        = '0;
        held        = 1'b0;
        marks_seen  = '0;
        prev_byte   = '0;
        prev_marked = 1'b0;
    endfunction

    function automatic int arg_total();
        return whole_line_arg ? 1 : 1 + int'(marks_seen);
    endfunction

    function automatic t_out_item line_reply(t_in_item it);
        t_out_item  r;
        logic       crlf;
        logic       done;
        logic       mark;
        logic [7:0] term;
        logic [7:0] last_ix;
        int         len;
        int         ix;
        logic       start;
        logic       sep;
        r = '0;
        case (t_cmd'(it.command))
            CMD_BYTE: begin
                crlf = (end_mode == MODE_CRLF);
                if (held) begin
                    r.status      = ST_BUSY;
                    r.line_length = fill;
                    r.arg_count   = 7'(arg_total());
                end else if (crlf && fill == 0 && it.rx_byte == CH_LF) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (crlf) begin
                        last_ix = fill - 8'd1;
                        done = (it.rx_byte == CH_LF && line_mem[last_ix][7:0] == CH_CR) ||
                               int'(fill) >= BUFFER_LENGTH - 2;
                    end else begin
                        term = (end_mode == MODE_CR) ? CH_CR : CH_LF;
                        done = (it.rx_byte == term) || int'(fill) >= BUFFER_LENGTH - 1;
                    end
                    if (!done) begin
                        mark = fill > 0 && prev_byte == CH_SPACE &&
                               it.rx_byte >= CH_ARG_LO && it.rx_byte <= CH_ARG_HI;
                        line_mem[fill] = {mark, it.rx_byte};
                        fill = fill + 8'd1;
                        if (mark && marks_seen < 7'd127)
                            marks_seen = marks_seen + 7'd1;
                        prev_marked   = mark;
                        prev_byte     = it.rx_byte;
                        r.status      = ST_STORED;
                        r.line_length = fill;
                    end else begin
                        if (crlf) begin
                            fill = fill - 8'd1;
                            if (prev_marked && marks_seen > 0)
                                marks_seen = marks_seen - 7'd1;
                        end
                        prev_byte   = '0;
                        prev_marked = 1'b0;
                        if (fill == 0) begin
                            drop_line();
                            r.status = ST_EMPTY;
                        end else if (arg_total() > MAX_ARGS) begin
                            r.status      = ST_TOO_MANY;
                            r.line_length = fill;
                            drop_line();
                        end else begin
                            held          = 1'b1;
                            r.status      = ST_READY;
                            r.line_length = fill;
                            r.arg_count   = 7'(arg_total());
                        end
                    end
                end
            end
            CMD_ERROR: begin
                if (held) begin
                    r.status      = ST_BUSY;
                    r.line_length = fill;
                    r.arg_count   = 7'(arg_total());
                end else begin
                    drop_line();
                    r.status = ST_CLEARED;
                end
            end
            CMD_READ: begin
                r.status = ST_READ;
                if (held) begin
                    len   = int'(fill);
                    ix    = int'(it.read_index);
                    start = (ix == 0) || (!whole_line_arg && ix < len && line_mem[ix][8]);
                    sep   = !whole_line_arg && ix + 1 < len &&
                            line_mem[ix][7:0] == CH_SPACE && line_mem[ix + 1][8];
                    r.line_length  = fill;
                    r.arg_count    = 7'(arg_total());
                    r.read_char    = (ix < len && !sep) ? line_mem[ix][7:0] : 8'd0;
                    r.is_arg_start = start;
                    r.is_separator = sep;
                end
            end
            default: begin
                if (held)
                    drop_line();
                r.status = ST_RELEASED;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            drop_line();
            end_mode       = MODE_CR;
            whole_line_arg = 1'b0;
            due_replies.delete();
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_replies.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d", i_out.status);
                    fail_tally++;
                end else begin
                    want = due_replies.pop_front();
                    check_field("status", 8'(want.status), 8'(i_out.status));
                    check_field("line_length", want.line_length, i_out.line_length);
                    check_field("arg_count", 8'(want.arg_count), 8'(i_out.arg_count));
                    check_field("read_char", want.read_char, i_out.read_char);
                    check_field("is_arg_start", 8'(want.is_arg_start), 8'(i_out.is_arg_start));
                    check_field("is_separator", 8'(want.is_separator), 8'(i_out.is_separator));
                end
            end
            if (i_in_valid && i_in_ready)
                due_replies.push_back(line_reply(i_in));
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_LINE_END_MODE: end_mode = t_line_mode'(i_cfg_data);
                    default:           whole_line_arg = i_cfg_data[0];
                endcase
            end
            o_outstanding <= due_replies.size();
        end
    end

endmodule

/* bench/tb_uart_line_assembler_tokenizer_core.sv */
`timescale 1ns / 1ps

module tb_uart_line_assembler_tokenizer_core;
    import ulat_pkg::*;

    localparam int BUFFER_LENGTH = 256;
    localparam int MAX_ARGS      = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 20;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_ready;
    t_out_item        out_item;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               results_due;
    int               fail_count;
    int               cycle_count = 0;
    int               sent_items = 0;
    int               calm_tx = 0;
    int               calm_rx = 0;
    t_line_mode       cur_mode = MODE_CR;

    t_line_mode phase_mode [8] = '{MODE_CR, MODE_LF, MODE_CRLF, MODE_ALT,
                                   MODE_CRLF, MODE_CR, MODE_LF, MODE_ALT};
    logic       phase_at [8]   = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    always #2 clk = ~clk;

    uart_line_assembler_tokenizer_core #(
        .BUFFER_LENGTH(BUFFER_LENGTH),
        .MAX_ARGS     (MAX_ARGS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    ulat_line_checker #(
        .BUFFER_LENGTH(BUFFER_LENGTH),
        .MAX_ARGS     (MAX_ARGS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_outstanding(results_due),
        .o_failures   (fail_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The result side holds ready low for a random number of cycles once a transfer is offered.
    initial begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (calm_rx > 0) begin
                stall = 0;
                calm_rx--;
            end else if ($urandom_range(0, 19) == 0) begin
                stall   = 0;
                calm_rx = $urandom_range(10, 40);
            end else begin
                stall = $urandom_range(0, 6);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
                repeat (stall - 1) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic push_item(input t_cmd c, input logic [7:0] b, input logic [7:0] ix);
        int gap;
        if (calm_tx > 0) begin
            gap = 0;
            calm_tx--;
        end else if ($urandom_range(0, 19) == 0) begin
            gap     = 0;
            calm_tx = $urandom_range(10, 40);
        end else begin
            gap = $urandom_range(0, 6);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= '{command: c, rx_byte: b, read_index: ix};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(CMD_BYTE, b, 8'($urandom));
    endtask

    task automatic push_cmd(input t_cmd c, input logic [7:0] ix);
        push_item(c, 8'($urandom), ix);
    endtask

    task automatic push_terminator();
        case (cur_mode)
            MODE_CR:   push_byte(CH_CR);
            MODE_CRLF: begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
            default:   push_byte(CH_LF);
        endcase
    endtask

    // Waits until every expected result has been received and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input t_line_mode m, input logic at);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LINE_END_MODE;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= CFG_AT_MODE;
        cfg_data  <= {1'b0, at};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_mode = m;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        if ($urandom_range(0, 11) == 0) begin
            b = 8'($urandom);
            if (b == CH_CR || b == CH_LF)
                b = b ^ 8'h80;
        end else begin
            b = 8'($urandom_range(8'h21, 8'h7E));
        end
        return b;
    endfunction

    task automatic send_word_line(input int words, output int nbytes);
        int n;
        n = 0;
        if ($urandom_range(0, 7) == 0) begin
            push_byte(CH_SPACE);
            n++;
        end
        for (int w = 0; w < words; w++) begin
            if (w > 0) begin
                repeat (($urandom_range(0, 5) == 0) ? 2 : 1) begin
                    push_byte(CH_SPACE);
                    n++;
                end
            end
            repeat ($urandom_range(1, 6)) begin
                push_byte(text_byte());
                n++;
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            push_byte(CH_SPACE);
            n++;
        end
        push_terminator();
        nbytes = n;
    endtask

    task automatic read_back(input int len);
        int ix;
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0)
                ix = $urandom_range(0, 255);
            else
                ix = $urandom_range(0, (len + 1 > 255) ? 255 : len + 1);
            push_cmd(CMD_READ, 8'(ix));
        end
    endtask

    // Fills the store until it overflows, with an argument start sent as byte 253.
    task automatic send_long_line();
        for (int k = 0; k < 256; k++) begin
            if (k == 252)
                push_byte(CH_SPACE);
            else if (k == 253)
                push_byte(8'h51);
            else if (k > 0 && $urandom_range(0, 23) == 0)
                push_byte(CH_SPACE);
            else
                push_byte(text_byte());
        end
        push_cmd(CMD_READ, 8'd252);
        push_cmd(CMD_READ, 8'd253);
        push_cmd(CMD_READ, 8'd254);
        read_back(255);
        push_cmd(CMD_RELEASE, 8'($urandom));
    endtask

    initial begin
        int goal;
        int nbytes;
        int pick;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LINE_END_MODE;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(MODE_CR, 1'b0);
        push_cmd(CMD_READ, 8'd0);
        push_cmd(CMD_RELEASE, 8'd0);
        push_cmd(CMD_ERROR, 8'd0);
        push_byte(CH_CR);
        push_byte(8'h00);
        push_byte(CH_SPACE);
        push_byte(8'h21);
        push_byte(CH_SPACE);
        push_byte(8'h22);
        push_byte(CH_SPACE);
        push_byte(8'h7E);
        push_byte(CH_SPACE);
        push_byte(8'h7D);
        push_byte(CH_CR);
        push_cmd(CMD_READ, 8'd0);
        push_cmd(CMD_READ, 8'd3);
        push_cmd(CMD_READ, 8'd8);
        push_cmd(CMD_READ, 8'd255);
        push_byte(8'hFF);
        push_cmd(CMD_ERROR, 8'd0);
        push_cmd(CMD_RELEASE, 8'd0);
        settle();

        set_config(MODE_CRLF, 1'b0);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);

        for (int p = 0; p < 8; p++) begin
            settle();
            set_config(phase_mode[p], phase_at[p]);
            if (p == 0 || p == 2)
                send_long_line();
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal) begin
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    send_word_line(($urandom_range(0, 4) == 0) ? $urandom_range(12, 20)
                                                                : $urandom_range(1, 6), nbytes);
                    read_back(nbytes);
                    if ($urandom_range(0, 3) == 0)
                        push_byte(text_byte());
                    if ($urandom_range(0, 3) == 0)
                        push_cmd(CMD_ERROR, 8'($urandom));
                    push_cmd(CMD_RELEASE, 8'($urandom));
                end else if (pick < 16) begin
                    repeat ($urandom_range(1, 4))
                        push_item(t_cmd'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                    push_cmd(CMD_RELEASE, 8'($urandom));
                end else if (pick < 18) begin
                    repeat ($urandom_range(1, 8)) push_byte(text_byte());
                    case ($urandom_range(0, 2))
                        0: push_cmd(CMD_ERROR, 8'($urandom));
                        1: begin
                            push_byte((cur_mode == MODE_CR) ? CH_LF : CH_CR);
                            push_byte(text_byte());
                            push_terminator();
                            push_cmd(CMD_RELEASE, 8'($urandom));
                        end
                        default: begin
                            push_terminator();
                            push_cmd(CMD_ERROR, 8'($urandom));
                            push_cmd(CMD_RELEASE, 8'($urandom));
                        end
                    endcase
                end else begin
                    push_terminator();
                    if (cur_mode == MODE_CRLF)
                        push_byte(CH_LF);
                end
            end
        end
        settle();
        repeat (8) @(posedge clk);

        if (fail_count == 0 && results_due == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
